// File: src/buddy_pkg.sv
// ---------------------------------------------------------------------------
// buddy_pkg
// Shared types, constants and helpers for the buddy allocator.
// ---------------------------------------------------------------------------
package buddy_pkg;

    // default pool size in units (power of two)
    localparam int DEF_TOTAL_UNITS = 1024;

    // fixed field widths of the item words
    localparam int REQ_W   = 16;
    localparam int START_W = 10;
    localparam int SIZE_W  = 11;
    localparam int LOG_W   = 5;

    // operation codes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // input word
    typedef struct packed {
        logic               op;
        logic [REQ_W-1:0]   request_size;
        logic [START_W-1:0] free_start;
    } req_word_t;

    // result word
    typedef struct packed {
        logic               success;
        logic [START_W-1:0] block_start;
        logic [SIZE_W-1:0]  block_size;
    } rsp_word_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_A_ROOT,
        ST_A_DOWN,
        ST_F_DOWN,
        ST_UP,
        ST_DONE
    } state_t;

    // exponent of the smallest power of two not below req (req of zero is rejected apart)
    function automatic logic [LOG_W-1:0] ceil_log2_req(input logic [REQ_W-1:0] req);
        logic [REQ_W-1:0] m;
        logic [LOG_W-1:0] r;
        m = req - REQ_W'(1);
        r = '0;
        for (int i = 0; i < REQ_W; i++)
        begin
            if (m[i])
            begin
                r = LOG_W'(i + 1);
            end
        end
        return r;
    endfunction

endpackage

// File: src/buddy_ram.sv
// ---------------------------------------------------------------------------
// buddy_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module buddy_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 2047
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// File: src/buddy_alu.sv
// ---------------------------------------------------------------------------
// buddy_alu
// Shared compare and merge unit: fit test on the way down, parent
// maximum with buddy merge on the way up.
// ---------------------------------------------------------------------------
module buddy_alu #(
    parameter int W = 11
) (
    input  logic [W-1:0] a,
    input  logic [W-1:0] b,
    input  logic [W-1:0] span,
    input  logic         merge_en,
    output logic         ge,
    output logic [W-1:0] merged
);

    logic [W:0]   sum;
    logic [W-1:0] larger;

    // fit compare
    assign ge = (a >= b);

    // parent value: max of children, or the whole span when both halves are free
    assign sum    = {1'b0, a} + {1'b0, b};
    assign larger = ge ? a : b;
    assign merged = (merge_en && (sum == {1'b0, span})) ? span : larger;

endmodule

// File: src/buddy_seq.sv
// ---------------------------------------------------------------------------
// buddy_seq
// Tree walk sequencer: clearing pass, descent, and path update back to
// the root, one tree level per cycle through the shared unit.
// ---------------------------------------------------------------------------
module buddy_seq #(
    parameter int TOTAL_UNITS = buddy_pkg::DEF_TOTAL_UNITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    output logic                                req_stall,
    input  buddy_pkg::req_word_t                req_word,
    output logic                                res_valid,
    input  logic                                res_take,
    output buddy_pkg::rsp_word_t                res_word,
    output logic                                ram_we,
    output logic [$clog2(2*TOTAL_UNITS-1)-1:0]  ram_waddr,
    output logic [$clog2(TOTAL_UNITS)+1:0]      ram_wdata,
    output logic [$clog2(2*TOTAL_UNITS-1)-1:0]  ram_raddr,
    input  logic [$clog2(TOTAL_UNITS)+1:0]      ram_rdata
);

    localparam int LEVELS     = $clog2(TOTAL_UNITS);
    localparam int LFB_W      = LEVELS + 1;
    localparam int NODE_COUNT = 2 * TOTAL_UNITS - 1;
    localparam int NODE_W     = $clog2(NODE_COUNT);
    localparam int CMP_W      = ((LEVELS > buddy_pkg::START_W) ? LEVELS
                                                               : buddy_pkg::START_W) + 1;

    buddy_pkg::state_t    state_reg, state_next;
    logic [NODE_W-1:0]    node_reg, node_next;
    logic [NODE_W-1:0]    lvl_end_reg, lvl_end_next;
    logic [LFB_W-1:0]     span_reg, span_next;
    logic [LEVELS-1:0]    offset_reg, offset_next;
    logic [LFB_W-1:0]     want_reg, want_next;
    logic [LFB_W-1:0]     cur_reg, cur_next;
    logic [buddy_pkg::START_W-1:0] start_reg, start_next;
    logic                 op_reg, op_next;
    buddy_pkg::rsp_word_t res_reg, res_next;

    logic                          accept;
    logic [buddy_pkg::LOG_W-1:0]   want_log;
    logic                          alloc_bad;
    logic [LFB_W-1:0]              rd_lfb;
    logic                          rd_taken;
    logic [LFB_W-1:0]              half;
    logic [LFB_W-1:0]              span_up;
    logic [NODE_W-1:0]             left_child;
    logic [NODE_W-1:0]             right_child;
    logic [NODE_W-1:0]             parent;
    logic [NODE_W-1:0]             sibling;
    logic [NODE_W-1:0]             parent_sibling;
    logic [NODE_W-1:0]             fit_child;
    logic [NODE_W-1:0]             fit_other;
    logic [NODE_W-1:0]             fit_grand;
    logic [NODE_W-1:0]             free_child;
    logic [LEVELS-1:0]             offset_half;
    logic [CMP_W-1:0]              offset_ext;
    logic [CMP_W-1:0]              start_ext;
    logic [CMP_W-1:0]              mid_ext;
    logic                          go_left;
    logic                          free_hit;
    logic                          half_hit;
    logic                          root_hit;
    logic                          clr_last;
    logic [LFB_W-1:0]              alu_b;
    logic                          alu_ge;
    logic [LFB_W-1:0]              alu_merged;

    // shared compare / merge unit
    assign alu_b = (state_reg == buddy_pkg::ST_UP) ? cur_reg : want_reg;

    buddy_alu #(
        .W (LFB_W)
    ) u_alu (
        .a        (rd_lfb),
        .b        (alu_b),
        .span     (span_up),
        .merge_en (op_reg == buddy_pkg::OP_FREE),
        .ge       (alu_ge),
        .merged   (alu_merged)
    );

    // request decode
    assign req_stall = (state_reg != buddy_pkg::ST_IDLE);
    assign accept    = req_valid && !req_stall;
    assign want_log  = buddy_pkg::ceil_log2_req(req_word.request_size);
    assign alloc_bad = (req_word.request_size == '0) || (32'(want_log) > LEVELS);

    // node arithmetic
    assign rd_lfb         = ram_rdata[LFB_W-1:0];
    assign rd_taken       = ram_rdata[LFB_W];
    assign half           = span_reg >> 1;
    assign span_up        = span_reg << 1;
    assign left_child     = NODE_W'({node_reg, 1'b0}) + NODE_W'(1);
    assign right_child    = left_child + NODE_W'(1);
    assign parent         = (node_reg - NODE_W'(1)) >> 1;
    assign sibling        = node_reg[0] ? (node_reg + NODE_W'(1)) : (node_reg - NODE_W'(1));
    assign parent_sibling = parent[0] ? (parent + NODE_W'(1)) : (parent - NODE_W'(1));
    assign fit_child      = alu_ge ? left_child : right_child;
    assign fit_other      = alu_ge ? right_child : left_child;
    assign fit_grand      = NODE_W'({fit_child, 1'b0}) + NODE_W'(1);
    assign offset_half    = offset_reg + half[LEVELS-1:0];

    // position compares for the free walk
    assign offset_ext = CMP_W'(offset_reg);
    assign start_ext  = CMP_W'(start_reg);
    assign mid_ext    = offset_ext + CMP_W'(half);
    assign go_left    = (mid_ext > start_ext);
    assign free_child = go_left ? left_child : right_child;
    assign free_hit   = (offset_ext == start_ext) && rd_taken;

    assign half_hit = (half == want_reg);
    assign root_hit = (span_reg == want_reg);
    assign clr_last = (node_reg == NODE_W'(NODE_COUNT - 1));

    assign res_valid = (state_reg == buddy_pkg::ST_DONE);
    assign res_word  = res_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            buddy_pkg::ST_CLEAR:
            begin
                if (clr_last)
                begin
                    state_next = buddy_pkg::ST_IDLE;
                end
            end
            buddy_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (req_word.op == buddy_pkg::OP_FREE)
                    begin
                        state_next = buddy_pkg::ST_F_DOWN;
                    end
                    else if (alloc_bad)
                    begin
                        state_next = buddy_pkg::ST_DONE;
                    end
                    else
                    begin
                        state_next = buddy_pkg::ST_A_ROOT;
                    end
                end
            end
            buddy_pkg::ST_A_ROOT:
            begin
                if (!alu_ge || root_hit)
                begin
                    state_next = buddy_pkg::ST_DONE;
                end
                else
                begin
                    state_next = buddy_pkg::ST_A_DOWN;
                end
            end
            buddy_pkg::ST_A_DOWN:
            begin
                if (half_hit)
                begin
                    state_next = buddy_pkg::ST_UP;
                end
            end
            buddy_pkg::ST_F_DOWN:
            begin
                if (free_hit)
                begin
                    state_next = (node_reg == '0) ? buddy_pkg::ST_DONE : buddy_pkg::ST_UP;
                end
                else if (span_reg == LFB_W'(1))
                begin
                    state_next = buddy_pkg::ST_DONE;
                end
            end
            buddy_pkg::ST_UP:
            begin
                if (parent == '0)
                begin
                    state_next = buddy_pkg::ST_DONE;
                end
            end
            buddy_pkg::ST_DONE:
            begin
                if (res_take)
                begin
                    state_next = buddy_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = buddy_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        node_next    = node_reg;
        lvl_end_next = lvl_end_reg;
        span_next    = span_reg;
        offset_next  = offset_reg;
        want_next    = want_reg;
        cur_next     = cur_reg;
        start_next   = start_reg;
        op_next      = op_reg;
        res_next     = res_reg;
        ram_we       = 1'b0;
        ram_waddr    = node_reg;
        ram_wdata    = {1'b0, span_reg};
        ram_raddr    = '0;
        unique case (state_reg)
            buddy_pkg::ST_CLEAR:
            begin
                // one node per cycle, span halves at the end of each level
                ram_we    = 1'b1;
                node_next = node_reg + NODE_W'(1);
                if (node_reg == lvl_end_reg)
                begin
                    span_next    = half;
                    lvl_end_next = NODE_W'({lvl_end_reg, 1'b0}) + NODE_W'(2);
                end
            end
            buddy_pkg::ST_IDLE:
            begin
                node_next   = '0;
                span_next   = LFB_W'(TOTAL_UNITS);
                offset_next = '0;
                if (accept)
                begin
                    op_next    = req_word.op;
                    start_next = req_word.free_start;
                    want_next  = LFB_W'(1) << want_log;
                    res_next   = '0;
                end
            end
            buddy_pkg::ST_A_ROOT:
            begin
                if (!alu_ge)
                begin
                    res_next = '0;
                end
                else if (root_hit)
                begin
                    // whole pool taken at the root
                    ram_we    = 1'b1;
                    ram_waddr = node_reg;
                    ram_wdata = {1'b1, LFB_W'(0)};
                    res_next.success     = 1'b1;
                    res_next.block_start = '0;
                    res_next.block_size  = buddy_pkg::SIZE_W'(span_reg);
                end
                else
                begin
                    ram_raddr = left_child;
                end
            end
            buddy_pkg::ST_A_DOWN:
            begin
                // leftmost child with room
                node_next = fit_child;
                span_next = half;
                if (!alu_ge)
                begin
                    offset_next = offset_half;
                end
                if (half_hit)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = fit_child;
                    ram_wdata = {1'b1, LFB_W'(0)};
                    cur_next  = '0;
                    ram_raddr = fit_other;
                    res_next.success     = 1'b1;
                    res_next.block_start = buddy_pkg::START_W'(alu_ge ? offset_reg : offset_half);
                    res_next.block_size  = buddy_pkg::SIZE_W'(half);
                end
                else
                begin
                    ram_raddr = fit_grand;
                end
            end
            buddy_pkg::ST_F_DOWN:
            begin
                if (free_hit)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = node_reg;
                    ram_wdata = {1'b0, span_reg};
                    cur_next  = span_reg;
                    ram_raddr = sibling;
                    res_next.success     = 1'b1;
                    res_next.block_start = start_reg;
                    res_next.block_size  = buddy_pkg::SIZE_W'(span_reg);
                end
                else if (span_reg == LFB_W'(1))
                begin
                    res_next = '0;
                end
                else
                begin
                    // follow the start position
                    node_next = free_child;
                    span_next = half;
                    if (!go_left)
                    begin
                        offset_next = offset_half;
                    end
                    ram_raddr = free_child;
                end
            end
            buddy_pkg::ST_UP:
            begin
                // parent gets max of children, merged when both halves free
                ram_we    = 1'b1;
                ram_waddr = parent;
                ram_wdata = {1'b0, alu_merged};
                cur_next  = alu_merged;
                node_next = parent;
                span_next = span_up;
                ram_raddr = parent_sibling;
            end
            buddy_pkg::ST_DONE:
            begin
                ram_raddr = '0;
            end
            default:
            begin
                ram_raddr = '0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= buddy_pkg::ST_CLEAR;
            node_reg    <= '0;
            lvl_end_reg <= '0;
            span_reg    <= LFB_W'(TOTAL_UNITS);
        end
        else
        begin
            state_reg   <= state_next;
            node_reg    <= node_next;
            lvl_end_reg <= lvl_end_next;
            span_reg    <= span_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        offset_reg <= offset_next;
        want_reg   <= want_next;
        cur_reg    <= cur_next;
        start_reg  <= start_next;
        op_reg     <= op_next;
        res_reg    <= res_next;
    end

endmodule

// File: src/buddy_allocator.sv
// ---------------------------------------------------------------------------
// buddy_allocator
// Binary buddy allocator over a pool of TOTAL_UNITS units; the tree of
// largest-free values and taken marks lives in one RAM, walked a level
// per cycle.
// ---------------------------------------------------------------------------
// throughput: one word at a time, bound by the single RAM read port that
//   serves one tree level per cycle on the way down and on the way up
// reset: a clearing pass writes all 2*TOTAL_UNITS-1 nodes before the first
//   word is taken
module buddy_allocator #(
    parameter int TOTAL_UNITS = buddy_pkg::DEF_TOTAL_UNITS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_stall,
    input  buddy_pkg::req_word_t req_word,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output buddy_pkg::rsp_word_t rsp_word
);

    localparam int NODE_COUNT = 2 * TOTAL_UNITS - 1;
    localparam int NODE_W     = $clog2(NODE_COUNT);
    localparam int WORD_W     = $clog2(TOTAL_UNITS) + 2;

    logic                 res_valid;
    logic                 res_take;
    buddy_pkg::rsp_word_t res_word;
    logic                 ram_we;
    logic [NODE_W-1:0]    ram_waddr;
    logic [WORD_W-1:0]    ram_wdata;
    logic [NODE_W-1:0]    ram_raddr;
    logic [WORD_W-1:0]    ram_rdata;

    logic                 rsp_valid_reg;
    buddy_pkg::rsp_word_t rsp_word_reg;

    buddy_seq #(
        .TOTAL_UNITS (TOTAL_UNITS)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_word  (req_word),
        .res_valid (res_valid),
        .res_take  (res_take),
        .res_word  (res_word),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    buddy_ram #(
        .WIDTH (WORD_W),
        .DEPTH (NODE_COUNT)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // output register takes a result when empty or draining
    assign res_take = res_valid && (!rsp_valid_reg || !rsp_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (res_take)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            rsp_word_reg <= res_word;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_word  = rsp_word_reg;

endmodule
